FILE: hdl/bfdh_pkg.sv
// shared types and constants for the double-hash bloom filter
`default_nettype none

package bfdh_pkg;

    // field and register widths
    localparam int HASH_W    = 32;
    localparam int MOD_W     = 13;
    localparam int HASHES_W  = 5;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [MOD_W-1:0]    FILTER_BITS_RESET = 13'd4096;
    localparam logic [HASHES_W-1:0] NUM_HASHES_RESET  = 5'd3;

    // reduction runs two dividend bits per step over both hashes
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = (2 * HASH_W) / DIV_BITS_PER_STEP;
    localparam int STEP_W            = $clog2(DIV_STEPS);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_BITS = 2'd0,
        REG_NUM_HASHES  = 2'd1
    } cfg_reg_t;

    // item action codes
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_QUERY  = 1'b1
    } action_t;

    // shared unit operations
    typedef enum logic [1:0] {
        UOP_DIV = 2'b01,
        UOP_ADD = 2'b10
    } unit_op_t;

endpackage

`default_nettype wire

FILE: hdl/bfdh_mod_unit.sv
// shared modular arithmetic unit: two restoring division steps or one modular add
`default_nettype none

module bfdh_mod_unit (
    input  bfdh_pkg::unit_op_t                op,
    input  logic [bfdh_pkg::MOD_W-1:0]        rem,
    input  logic [bfdh_pkg::MOD_W-1:0]        addend,
    input  logic [bfdh_pkg::MOD_W-1:0]        modulus,
    input  logic [1:0]                        bits,
    output logic [bfdh_pkg::MOD_W-1:0]        result
);
    import bfdh_pkg::*;

    logic [MOD_W:0]   first_in;
    logic [MOD_W-1:0] first_out;
    logic [MOD_W-1:0] second_out;

    // subtract the modulus once if the value reached it
    function automatic logic [MOD_W-1:0] cond_sub(input logic [MOD_W:0] x,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W:0] d;
        d = x - {1'b0, m};
        if (x >= {1'b0, m})
            return d[MOD_W-1:0];
        return x[MOD_W-1:0];
    endfunction

    // first compare-subtract takes either the sum or the shifted remainder
    always_comb
    begin
        unique case (op)
            UOP_ADD: first_in = {1'b0, rem} + {1'b0, addend};
            UOP_DIV: first_in = {rem, bits[1]};
            default: first_in = {rem, bits[1]};
        endcase
        first_out  = cond_sub(first_in, modulus);
        second_out = cond_sub({first_out, bits[0]}, modulus);
    end

    // add uses one stage, division uses both
    always_comb
    begin
        unique case (op)
            UOP_ADD: result = first_out;
            UOP_DIV: result = second_out;
            default: result = second_out;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/bfdh_bit_mem.sv
// single-port bit array with registered read data
`default_nettype none

module bfdh_bit_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic          wdata,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    // write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/bloom_filter_double_hash_top.sv
// top level: sequencer, configuration registers and bit array of the bloom filter
`default_nettype none

// Bloom filter over a bit array of MAX_BITS entries, driven by two precomputed
// hashes per item. After reset the array is cleared one entry per cycle, and
// busy stays high until the clearing pass ends, before the first item is
// taken; configuration writes are accepted throughout. An item is taken on
// start while busy is low. Both hashes are reduced modulo filter_bits
// (clamped to 1..MAX_BITS) by one shared compare-subtract unit at two bits per
// cycle, then the same unit steps the probe position once per cycle while the
// single-port bit array is written (insert) or read (query) for max(k,2)
// probes, with k clamped to MAX_HASHES (16 by default). done pulses for one
// cycle with is_member after the drain state; busy is already low in that
// cycle, so the next item can start then. The receiver cannot stall the
// result: it must take it on the done cycle.
module bloom_filter_double_hash_top #(
    parameter int MAX_BITS   = 4096,
    parameter int MAX_HASHES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [bfdh_pkg::HASH_W-1:0]      first_hash,
    input  logic [bfdh_pkg::HASH_W-1:0]      second_hash,
    output logic                             done,
    output logic                             is_member,
    input  logic                             cfg_write,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfdh_pkg::CFG_W-1:0]       cfg_data
);
    import bfdh_pkg::*;

    localparam int AW = $clog2(MAX_BITS);
    localparam int KW = $clog2(MAX_HASHES + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_PROBE = 6'b001000,
        S_DRAIN = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [MOD_W-1:0]    filter_bits_reg;
    logic [HASHES_W-1:0] num_hashes_reg;

    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [STEP_W-1:0]   step_cnt_reg, step_cnt_next;
    logic [KW-1:0]       probe_cnt_reg, probe_cnt_next;
    logic                rvalid_reg, rvalid_next;
    logic                done_reg, done_next;

    logic [2*HASH_W-1:0] dividend_reg, dividend_next;
    logic [MOD_W-1:0]    rem_reg, rem_next;
    logic [MOD_W-1:0]    acc_reg, acc_next;
    logic [MOD_W-1:0]    r2_reg, r2_next;
    logic [MOD_W-1:0]    m_reg, m_next;
    logic [KW-1:0]       nprobe_reg, nprobe_next;
    logic                query_reg, query_next;
    logic                all_reg, all_next;
    logic                member_reg, member_next;

    logic [MOD_W-1:0]    m_eff;
    logic [KW-1:0]       k_eff;
    logic [KW-1:0]       nprobe_eff;

    unit_op_t            unit_op;
    logic [MOD_W-1:0]    unit_rem;
    logic [MOD_W-1:0]    unit_out;

    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic                mem_wdata;
    logic                mem_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= FILTER_BITS_RESET;
            num_hashes_reg  <= NUM_HASHES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER_BITS: filter_bits_reg <= cfg_data[MOD_W-1:0];
                REG_NUM_HASHES:  num_hashes_reg  <= cfg_data[HASHES_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective modulus and probe count
    always_comb
    begin
        if (filter_bits_reg == '0)
            m_eff = MOD_W'(1);
        else if (32'(filter_bits_reg) > MAX_BITS)
            m_eff = MOD_W'(MAX_BITS);
        else
            m_eff = filter_bits_reg;

        if (32'(num_hashes_reg) > MAX_HASHES)
            k_eff = KW'(MAX_HASHES);
        else
            k_eff = KW'(num_hashes_reg);

        nprobe_eff = (k_eff < KW'(2)) ? KW'(2) : k_eff;
    end

    // shared arithmetic unit
    assign unit_op  = (state_reg == S_PROBE) ? UOP_ADD : UOP_DIV;
    assign unit_rem = (state_reg == S_PROBE) ? acc_reg : rem_reg;

    bfdh_mod_unit u_mod_unit (
        .op      (unit_op),
        .rem     (unit_rem),
        .addend  (r2_reg),
        .modulus (m_reg),
        .bits    (dividend_reg[2*HASH_W-1 -: DIV_BITS_PER_STEP]),
        .result  (unit_out)
    );

    // bit array access: clearing pass, then probes
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            S_PROBE:
            begin
                mem_we    = !query_reg;
                mem_wdata = 1'b1;
                mem_addr  = (probe_cnt_reg == '0) ? AW'(r2_reg) : AW'(acc_reg);
            end
            default: ;
        endcase
    end

    bfdh_bit_mem #(
        .DEPTH (MAX_BITS),
        .AW    (AW)
    ) u_bit_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        step_cnt_next  = step_cnt_reg;
        probe_cnt_next = probe_cnt_reg;
        rvalid_next    = 1'b0;
        done_next      = 1'b0;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        r2_next        = r2_reg;
        m_next         = m_reg;
        nprobe_next    = nprobe_reg;
        query_next     = query_reg;
        all_next       = all_reg;
        member_next    = member_reg;

        // fold in read data in the cycle after each query probe
        if (rvalid_reg)
            all_next = all_reg & mem_rdata;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_BITS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    dividend_next = {first_hash, second_hash};
                    rem_next      = '0;
                    step_cnt_next = '0;
                    m_next        = m_eff;
                    nprobe_next   = nprobe_eff;
                    query_next    = (action == ACT_QUERY);
                    all_next      = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                dividend_next = dividend_reg << DIV_BITS_PER_STEP;
                rem_next      = unit_out;
                step_cnt_next = step_cnt_reg + 1'b1;
                // first hash done: keep it as the probe start
                if (step_cnt_reg == STEP_W'(DIV_STEPS / 2 - 1))
                begin
                    acc_next = unit_out;
                    rem_next = '0;
                end
                if (step_cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    r2_next        = unit_out;
                    probe_cnt_next = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE:
            begin
                rvalid_next    = query_reg;
                probe_cnt_next = probe_cnt_reg + 1'b1;
                // the first probe uses the stride itself
                if (probe_cnt_reg != '0)
                    acc_next = unit_out;
                if (probe_cnt_reg == nprobe_reg - 1'b1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                done_next   = 1'b1;
                member_next = query_reg & all_reg & (!rvalid_reg | mem_rdata);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            step_cnt_reg  <= '0;
            probe_cnt_reg <= '0;
            rvalid_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            step_cnt_reg  <= step_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            rvalid_reg    <= rvalid_next;
            done_reg      <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        r2_reg       <= r2_next;
        m_reg        <= m_next;
        nprobe_reg   <= nprobe_next;
        query_reg    <= query_next;
        all_reg      <= all_next;
        member_reg   <= member_next;
    end

    // outputs
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign is_member = member_reg;

`ifndef SYNTHESIS
    // a result only follows the drain cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_DRAIN))
        else $error("result strobe without drain");

    // a query never writes the array
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE && query_reg) |-> !mem_we)
        else $error("array written during query");

    // probe positions stay below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (acc_reg < m_reg && r2_reg < m_reg))
        else $error("probe position out of range");

    // the probe counter stays inside the probe count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (probe_cnt_reg < nprobe_reg))
        else $error("probe counter overrun");

    // read data is only expected right after a query probe
    assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> $past(state_reg == S_PROBE && query_reg))
        else $error("stray read valid");
`endif

endmodule

`default_nettype wire
